// ----- sv/tbc_pkg.sv -----
// Package for the teletraffic blocking calculator: widths, codes, state types
// and the request/response structs of the shared divider. Depends on nothing.
package tbc_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int MAX_SERVERS = 1023;

   localparam int FUNC_W  = 2;
   localparam int CNT_W   = 10;
   localparam int TRF_W   = 32;
   localparam int RETRY_W = 16;
   localparam int PROB_W  = FRAC_BITS + 1;

   // shared multiplier: traffic-wide by probability-wide
   localparam int MUL_A_W = TRF_W;
   localparam int MUL_B_W = PROB_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int AS_W    = PROD_W - FRAC_BITS;

   // shared divider
   localparam int NUM_W   = 60;
   localparam int DEN_W   = 50;
   localparam int QBITS   = PROB_W + 1;
   localparam int DSH_W   = DEN_W + QBITS - 1;
   localparam int DCNT_W  = $clog2(QBITS);

   localparam logic [PROB_W-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [FUNC_W-1:0] {
      FN_PLAIN_B  = 2'd0,
      FN_EXT_B    = 2'd1,
      FN_ERLANG_C = 2'd2,
      FN_TRUNKS   = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_AS,
      ST_LOAD_AS,
      ST_WAIT_R1,
      ST_MUL_P,
      ST_MUL_KD,
      ST_START_X,
      ST_WAIT_X,
      ST_STEP_END,
      ST_MUL_AB,
      ST_MUL_BN,
      ST_START_C,
      ST_WAIT_C
   } seq_state_type;

   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_ROUND
   } div_state_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROB_W-1:0] quot;
   } div_rsp_type;

endpackage

// ----- sv/tbc_div.sv -----
// Serial restoring divider: round-half-up of num*2^0/den, saturated at one.
// Depends on tbc_pkg.
module tbc_div (
   input  logic                clock,
   input  logic                reset,
   input  tbc_pkg::div_req_type req,
   output tbc_pkg::div_rsp_type rsp
);

   tbc_pkg::div_state_type state_ff, state_in;
   logic [tbc_pkg::NUM_W-1:0]  rem_ff, rem_in;
   logic [tbc_pkg::DSH_W-1:0]  dsh_ff, dsh_in;
   logic [tbc_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [tbc_pkg::QBITS-1:0]  quo_ff, quo_in;
   logic [tbc_pkg::DCNT_W-1:0] cnt_ff, cnt_in;
   logic [tbc_pkg::PROB_W-1:0] quot_ff, quot_in;
   logic                       done_ff, done_in;

   logic                       fits;
   logic [tbc_pkg::DSH_W-1:0]  diff;
   logic                       round_up;
   logic [tbc_pkg::QBITS-1:0]  qsum;

   assign fits     = tbc_pkg::DSH_W'(rem_ff) >= dsh_ff;
   assign diff     = tbc_pkg::DSH_W'(rem_ff) - dsh_ff;
   assign round_up = {rem_ff, 1'b0} >= (tbc_pkg::NUM_W + 1)'(den_ff);
   assign qsum     = {1'b0, quo_ff[tbc_pkg::PROB_W-1:0]} + tbc_pkg::QBITS'(round_up);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbc_pkg::DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      rem_ff  <= rem_in;
      dsh_ff  <= dsh_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;
      case (state_ff)
         tbc_pkg::DV_IDLE: begin
            if (req.start) begin
               rem_in   = req.num;
               den_in   = req.den;
               dsh_in   = {req.den, {(tbc_pkg::QBITS-1){1'b0}}};
               quo_in   = '0;
               cnt_in   = tbc_pkg::DCNT_W'(tbc_pkg::QBITS - 1);
               state_in = tbc_pkg::DV_RUN;
            end
         end
         tbc_pkg::DV_RUN: begin
            if (fits) begin
               rem_in = diff[tbc_pkg::NUM_W-1:0];
            end
            quo_in = {quo_ff[tbc_pkg::QBITS-2:0], fits};
            dsh_in = dsh_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = tbc_pkg::DV_ROUND;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         tbc_pkg::DV_ROUND: begin
            // top bit set means the quotient is already past one
            if (quo_ff[tbc_pkg::QBITS-1] || qsum > tbc_pkg::QBITS'(tbc_pkg::ONE_Q)) begin
               quot_in = tbc_pkg::ONE_Q;
            end else begin
               quot_in = qsum[tbc_pkg::PROB_W-1:0];
            end
            done_in  = 1'b1;
            state_in = tbc_pkg::DV_IDLE;
         end
         default: begin
            state_in = tbc_pkg::DV_IDLE;
         end
      endcase
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// ----- sv/teletraffic_blocking_calc.sv -----
// Sequence: n recursion steps, one divide each for Erlang B and the trunk search and
//   two for extended Erlang B (up to 1023 steps for the search), plus one more divide for Erlang C.
//   Special cases answer the cycle after the request is taken.
//   Each divide goes through the serial divider (18 quotient bits, then a rounding state).
// Throughput: one word at a time; the next request is taken once the response is taken.
// Reset: synchronous, active high; clears sequencer, divider and response valid.
module teletraffic_blocking_calc (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tbc_pkg::FUNC_W-1:0]  req_func,
   input  logic [tbc_pkg::CNT_W-1:0]   req_server_count,
   input  logic [tbc_pkg::TRF_W-1:0]   req_traffic,
   input  logic [tbc_pkg::RETRY_W-1:0] req_retry_fraction,
   input  logic [tbc_pkg::PROB_W-1:0]  req_target_blocking,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tbc_pkg::PROB_W-1:0]  rsp_probability,
   output logic [tbc_pkg::CNT_W-1:0]   rsp_trunks,
   output logic                        rsp_error
);

   tbc_pkg::seq_state_type state_ff, state_in;
   tbc_pkg::func_type          func_ff, func_in;
   logic [tbc_pkg::CNT_W-1:0]   n_ff, n_in;
   logic [tbc_pkg::CNT_W-1:0]   k_ff, k_in;
   logic [tbc_pkg::TRF_W-1:0]   a_ff, a_in;
   logic [tbc_pkg::RETRY_W-1:0] retry_ff, retry_in;
   logic [tbc_pkg::PROB_W-1:0]  target_ff, target_in;
   logic [tbc_pkg::PROB_W-1:0]  s_ff, s_in;
   logic [tbc_pkg::PROB_W-1:0]  r1_ff, r1_in;
   logic [tbc_pkg::AS_W-1:0]    as_ff, as_in;
   logic [tbc_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [tbc_pkg::DEN_W-1:0]   pos_ff, pos_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tbc_pkg::PROB_W-1:0]  prob_ff, prob_in;
   logic [tbc_pkg::CNT_W-1:0]   trunks_ff, trunks_in;
   logic                        error_ff, error_in;

   logic [tbc_pkg::MUL_A_W-1:0] mul_a;
   logic [tbc_pkg::MUL_B_W-1:0] mul_b;
   logic [tbc_pkg::AS_W-1:0]    as_now;
   logic [tbc_pkg::PROB_W-1:0]  d_val;
   logic [tbc_pkg::DEN_W-1:0]   neg;
   logic                        accept;
   logic [tbc_pkg::CNT_W-1:0]   n_clamped;

   tbc_pkg::div_req_type div_req;
   tbc_pkg::div_rsp_type div_rsp;

   tbc_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_ready = (state_ff == tbc_pkg::ST_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign n_clamped = (req_server_count > tbc_pkg::CNT_W'(tbc_pkg::MAX_SERVERS))
                      ? tbc_pkg::CNT_W'(tbc_pkg::MAX_SERVERS) : req_server_count;

   // (A*s) >> F straight off the product register
   assign as_now = prod_ff[tbc_pkg::PROD_W-1:tbc_pkg::FRAC_BITS];
   // 1 - r1*retry, product still in the register
   assign d_val  = tbc_pkg::ONE_Q - prod_ff[tbc_pkg::PROB_W+tbc_pkg::FRAC_BITS-2:tbc_pkg::FRAC_BITS];
   assign neg    = tbc_pkg::DEN_W'({a_ff, {tbc_pkg::FRAC_BITS{1'b0}}});

   // shared multiplier, registered every cycle
   assign prod_in = tbc_pkg::PROD_W'(mul_a) * tbc_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tbc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff   <= func_in;
      n_ff      <= n_in;
      k_ff      <= k_in;
      a_ff      <= a_in;
      retry_ff  <= retry_in;
      target_ff <= target_in;
      s_ff      <= s_in;
      r1_ff     <= r1_in;
      as_ff     <= as_in;
      prod_ff   <= prod_in;
      pos_ff    <= pos_in;
      prob_ff   <= prob_in;
      trunks_ff <= trunks_in;
      error_ff  <= error_in;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      a_in         = a_ff;
      retry_in     = retry_ff;
      target_in    = target_ff;
      s_in         = s_ff;
      r1_in        = r1_ff;
      as_in        = as_ff;
      pos_in       = pos_ff;
      prob_in      = prob_ff;
      trunks_in    = trunks_ff;
      error_in     = error_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_a        = a_ff;
      mul_b        = s_ff;
      div_req      = '0;

      // drop the response word once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         tbc_pkg::ST_IDLE: begin
            if (accept) begin
               func_in   = tbc_pkg::func_type'(req_func);
               n_in      = n_clamped;
               a_in      = req_traffic;
               retry_in  = req_retry_fraction;
               target_in = req_target_blocking;
               s_in      = tbc_pkg::ONE_Q;
               k_in      = tbc_pkg::CNT_W'(1);
               prob_in   = '0;
               trunks_in = '0;
               error_in  = 1'b0;
               state_in  = tbc_pkg::ST_MUL_AS;
               case (tbc_pkg::func_type'(req_func))
                  tbc_pkg::FN_PLAIN_B, tbc_pkg::FN_EXT_B: begin
                     // zero traffic gives zero, zero servers gives one
                     if (req_traffic == '0) begin
                        rsp_valid_in = 1'b1;
                        state_in     = tbc_pkg::ST_IDLE;
                     end else if (n_clamped == '0) begin
                        prob_in      = tbc_pkg::ONE_Q;
                        rsp_valid_in = 1'b1;
                        state_in     = tbc_pkg::ST_IDLE;
                     end
                  end
                  tbc_pkg::FN_ERLANG_C: begin
                     if (n_clamped == '0) begin
                        error_in     = 1'b1;
                        rsp_valid_in = 1'b1;
                        state_in     = tbc_pkg::ST_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         tbc_pkg::ST_MUL_AS: begin
            mul_a    = a_ff;
            mul_b    = s_ff;
            state_in = tbc_pkg::ST_LOAD_AS;
         end
         tbc_pkg::ST_LOAD_AS: begin
            as_in         = as_now;
            div_req.start = 1'b1;
            div_req.num   = tbc_pkg::NUM_W'({as_now, {tbc_pkg::FRAC_BITS{1'b0}}});
            div_req.den   = tbc_pkg::DEN_W'({k_ff, {tbc_pkg::FRAC_BITS{1'b0}}})
                            + tbc_pkg::DEN_W'(as_now);
            state_in      = tbc_pkg::ST_WAIT_R1;
         end
         tbc_pkg::ST_WAIT_R1: begin
            if (div_rsp.done) begin
               r1_in = div_rsp.quot;
               if (func_ff == tbc_pkg::FN_EXT_B) begin
                  state_in = tbc_pkg::ST_MUL_P;
               end else begin
                  s_in     = div_rsp.quot;
                  state_in = tbc_pkg::ST_STEP_END;
               end
            end
         end
         tbc_pkg::ST_MUL_P: begin
            mul_a    = tbc_pkg::MUL_A_W'(r1_ff);
            mul_b    = tbc_pkg::MUL_B_W'(retry_ff);
            state_in = tbc_pkg::ST_MUL_KD;
         end
         tbc_pkg::ST_MUL_KD: begin
            mul_a    = tbc_pkg::MUL_A_W'(k_ff);
            mul_b    = d_val;
            state_in = tbc_pkg::ST_START_X;
         end
         tbc_pkg::ST_START_X: begin
            div_req.start = 1'b1;
            div_req.num   = tbc_pkg::NUM_W'({as_ff, {tbc_pkg::FRAC_BITS{1'b0}}});
            div_req.den   = tbc_pkg::DEN_W'(prod_ff) + tbc_pkg::DEN_W'(as_ff);
            state_in      = tbc_pkg::ST_WAIT_X;
         end
         tbc_pkg::ST_WAIT_X: begin
            if (div_rsp.done) begin
               s_in     = div_rsp.quot;
               state_in = tbc_pkg::ST_STEP_END;
            end
         end
         tbc_pkg::ST_STEP_END: begin
            if (func_ff == tbc_pkg::FN_TRUNKS) begin
               if (s_ff <= target_ff) begin
                  prob_in      = s_ff;
                  trunks_in    = k_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = tbc_pkg::ST_IDLE;
               end else if (k_ff == tbc_pkg::CNT_W'(tbc_pkg::MAX_SERVERS)) begin
                  error_in     = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = tbc_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = tbc_pkg::ST_MUL_AS;
               end
            end else if (k_ff == n_ff) begin
               if (func_ff == tbc_pkg::FN_ERLANG_C) begin
                  state_in = tbc_pkg::ST_MUL_AB;
               end else begin
                  prob_in      = s_ff;
                  rsp_valid_in = 1'b1;
                  state_in     = tbc_pkg::ST_IDLE;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = tbc_pkg::ST_MUL_AS;
            end
         end
         tbc_pkg::ST_MUL_AB: begin
            // A*B with B the Erlang B result held in s
            mul_a    = a_ff;
            mul_b    = s_ff;
            state_in = tbc_pkg::ST_MUL_BN;
         end
         tbc_pkg::ST_MUL_BN: begin
            pos_in   = tbc_pkg::DEN_W'({n_ff, {(2*tbc_pkg::FRAC_BITS){1'b0}}})
                       + tbc_pkg::DEN_W'(prod_ff);
            mul_a    = tbc_pkg::MUL_A_W'(n_ff);
            mul_b    = s_ff;
            state_in = tbc_pkg::ST_START_C;
         end
         tbc_pkg::ST_START_C: begin
            // a denominator of zero or less is an error
            if (pos_ff <= neg) begin
               error_in     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tbc_pkg::ST_IDLE;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = {prod_ff[tbc_pkg::NUM_W-2*tbc_pkg::FRAC_BITS-1:0],
                                {(2*tbc_pkg::FRAC_BITS){1'b0}}};
               div_req.den   = pos_ff - neg;
               state_in      = tbc_pkg::ST_WAIT_C;
            end
         end
         tbc_pkg::ST_WAIT_C: begin
            if (div_rsp.done) begin
               prob_in      = div_rsp.quot;
               rsp_valid_in = 1'b1;
               state_in     = tbc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tbc_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_probability = prob_ff;
   assign rsp_trunks      = trunks_ff;
   assign rsp_error       = error_ff;

endmodule

// ----- dv/tbc_checker.sv -----
`timescale 1ns / 100ps
// Checker for the blocking calculator: watches both channels, predicts each
// response from the accepted request and compares it. Depends on tbc_pkg.
module tbc_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [tbc_pkg::FUNC_W-1:0]  req_func,
   input  logic [tbc_pkg::CNT_W-1:0]   req_server_count,
   input  logic [tbc_pkg::TRF_W-1:0]   req_traffic,
   input  logic [tbc_pkg::RETRY_W-1:0] req_retry_fraction,
   input  logic [tbc_pkg::PROB_W-1:0]  req_target_blocking,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [tbc_pkg::PROB_W-1:0]  rsp_probability,
   input  logic [tbc_pkg::CNT_W-1:0]   rsp_trunks,
   input  logic                        rsp_error,
   output int                          failures,
   output int                          pending,
   output int                          words_checked
);

   typedef struct {
      logic [tbc_pkg::PROB_W-1:0] probability;
      logic [tbc_pkg::CNT_W-1:0]  trunks;
      logic                       error;
   } blocking_result_type;

   localparam bit [63:0] UNITY = 64'd1 << tbc_pkg::FRAC_BITS;

   blocking_result_type awaited_results[$];

   // round(num * 2^sh / den), saturating at cap
   function automatic bit [63:0] scaled_quotient(bit [63:0] num, int sh, bit [63:0] den,
                                                 bit [63:0] cap);
      bit [63:0] q;
      bit [63:0] rem;
      if (den == 0) return cap;
      q   = num / den;
      rem = num % den;
      if (q > cap) return cap;
      for (int i = 0; i < sh; i++) begin
         q   = q << 1;
         rem = rem << 1;
         if (rem >= den) begin
            rem = rem - den;
            q   = q + 1;
         end
         if (q > cap) return cap;
      end
      if (rem >= den - rem) q = q + 1;
      return (q > cap) ? cap : q;
   endfunction

   function automatic bit [63:0] erlang_step(bit [63:0] s, bit [63:0] k, bit [63:0] a);
      bit [63:0] as;
      as = (a * s) >> tbc_pkg::FRAC_BITS;
      return scaled_quotient(as, tbc_pkg::FRAC_BITS, (k << tbc_pkg::FRAC_BITS) + as, UNITY);
   endfunction

   function automatic bit [63:0] retry_step(bit [63:0] s, bit [63:0] k, bit [63:0] a,
                                            bit [63:0] retry);
      bit [63:0] as;
      bit [63:0] r1;
      bit [63:0] d;
      as = (a * s) >> tbc_pkg::FRAC_BITS;
      r1 = scaled_quotient(as, tbc_pkg::FRAC_BITS, (k << tbc_pkg::FRAC_BITS) + as, UNITY);
      d  = UNITY - ((r1 * retry) >> tbc_pkg::FRAC_BITS);
      return scaled_quotient(as, tbc_pkg::FRAC_BITS, k * d + as, UNITY);
   endfunction

   function automatic bit [63:0] blocking_run(bit [63:0] n, bit [63:0] a);
      bit [63:0] s;
      s = UNITY;
      for (bit [63:0] k = 1; k <= n; k++) s = erlang_step(s, k, a);
      return s;
   endfunction

   function automatic blocking_result_type predict_blocking(tbc_pkg::func_type fn,
      bit [63:0] n, bit [63:0] a, bit [63:0] retry, bit [63:0] target);
      blocking_result_type r;
      bit [63:0] s;
      bit [63:0] b;
      bit [63:0] pos;
      bit [63:0] neg;
      bit [63:0] k;
      r = '{default: '0};
      if (n > tbc_pkg::MAX_SERVERS) n = tbc_pkg::MAX_SERVERS;
      if (retry >= UNITY) retry = UNITY - 1;
      case (fn)
         tbc_pkg::FN_PLAIN_B, tbc_pkg::FN_EXT_B: begin
            if (a == 0) r.probability = '0;
            else if (n == 0) r.probability = tbc_pkg::ONE_Q;
            else if (fn == tbc_pkg::FN_PLAIN_B)
               r.probability = tbc_pkg::PROB_W'(blocking_run(n, a));
            else begin
               s = UNITY;
               for (k = 1; k <= n; k++) s = retry_step(s, k, a, retry);
               r.probability = tbc_pkg::PROB_W'(s);
            end
         end
         tbc_pkg::FN_ERLANG_C: begin
            if (n == 0) r.error = 1'b1;
            else begin
               b   = blocking_run(n, a);
               pos = (n << (2 * tbc_pkg::FRAC_BITS)) + a * b;
               neg = a << tbc_pkg::FRAC_BITS;
               if (pos <= neg) r.error = 1'b1;
               else r.probability = tbc_pkg::PROB_W'(scaled_quotient(b * n,
                       2 * tbc_pkg::FRAC_BITS, pos - neg, UNITY));
            end
         end
         default: begin
            // stop at the first count that meets the target
            s = UNITY;
            r.error = 1'b1;
            for (k = 1; k <= tbc_pkg::MAX_SERVERS; k++) begin
               s = erlang_step(s, k, a);
               if (s <= target) begin
                  r.trunks      = tbc_pkg::CNT_W'(k);
                  r.probability = tbc_pkg::PROB_W'(s);
                  r.error       = 1'b0;
                  break;
               end
            end
         end
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("checker: %s mismatch, got %0d want %0d at %0t", field, got, want, $realtime);
      failures++;
   endtask

   always @(posedge clock) begin
      blocking_result_type want;
      if (reset) begin
         failures      = 0;
         pending       = 0;
         words_checked = 0;
      end else begin
         if (req_valid && req_ready)
            awaited_results.push_back(predict_blocking(tbc_pkg::func_type'(req_func),
               64'(req_server_count), 64'(req_traffic), 64'(req_retry_fraction),
               64'(req_target_blocking)));
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_probability !== want.probability)
                  report_mismatch("probability", int'(rsp_probability),
                                  int'(want.probability));
               if (rsp_trunks !== want.trunks)
                  report_mismatch("trunks", int'(rsp_trunks), int'(want.trunks));
               if (rsp_error !== want.error)
                  report_mismatch("error", int'(rsp_error), int'(want.error));
            end
            words_checked++;
         end
         pending = awaited_results.size();
      end
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Top of the blocking calculator testbench: clock, reset, request stimulus,
// response back-pressure and verdict. Depends on tbc_pkg, the block and tbc_checker.
module testbench;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [tbc_pkg::FUNC_W-1:0]  req_func = '0;
   logic [tbc_pkg::CNT_W-1:0]   req_server_count = '0;
   logic [tbc_pkg::TRF_W-1:0]   req_traffic = '0;
   logic [tbc_pkg::RETRY_W-1:0] req_retry_fraction = '0;
   logic [tbc_pkg::PROB_W-1:0]  req_target_blocking = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [tbc_pkg::PROB_W-1:0]  rsp_probability;
   logic [tbc_pkg::CNT_W-1:0]   rsp_trunks;
   logic                        rsp_error;

   int failures;
   int pending;
   int words_checked;

   // idling percentages for the current phase
   int send_idle_pct  = 0;
   int drain_stall_pct = 0;
   // long hold-off of the response side, counted in the drain process
   int hold_off_cycles  = 0;
   int requests_sent    = 0;

   always #1 clock = ~clock;

   teletraffic_blocking_calc dut (.*);

   tbc_checker u_checker (.*);

   // Drive the response ready at each falling edge; once a few requests have gone,
   // hold it low for a long stretch so the block fills up and refuses further requests.
   initial begin
      bit hold_off_done;
      hold_off_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_off_done && requests_sent >= 24) begin
            hold_off_done = 1'b1;
            rsp_ready = 1'b0;
            for (int i = 0; i < 3000; i++) begin
               @(negedge clock);
               hold_off_cycles++;
            end
         end
         rsp_ready = ($urandom_range(99) >= drain_stall_pct);
      end
   end

   // Offer one request word and hold it until it is taken.
   task automatic send_request(tbc_pkg::func_type fn, int unsigned n,
                               logic [tbc_pkg::TRF_W-1:0] a,
                               logic [tbc_pkg::RETRY_W-1:0] retry,
                               logic [tbc_pkg::PROB_W-1:0] target);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid           = 1'b1;
      req_func            = fn;
      req_server_count    = n[tbc_pkg::CNT_W-1:0];
      req_traffic         = a;
      req_retry_fraction  = retry;
      req_target_blocking = target;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_random_request();
      int unsigned n;
      logic [tbc_pkg::TRF_W-1:0] a;
      // keep most server counts small so the recursion stays short
      n = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(30);
      case ($urandom_range(3))
         0: a = $urandom;
         1: a = $urandom_range(8) << 16;
         default: a = $urandom_range(32'h28_0000);
      endcase
      send_request(tbc_pkg::func_type'($urandom_range(3)), n, a,
                   tbc_pkg::RETRY_W'($urandom),
                   tbc_pkg::PROB_W'(($urandom_range(3) == 0) ? $urandom_range(65536)
                                                             : $urandom_range(6000)));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: field extremes and every special case
      send_request(tbc_pkg::FN_PLAIN_B, 10, 32'h0005_0000, 16'h0, 17'h0);
      send_request(tbc_pkg::FN_PLAIN_B, 10, 32'h0, 16'h0, 17'h0);         // zero traffic
      send_request(tbc_pkg::FN_PLAIN_B, 0, 32'h0001_0000, 16'h0, 17'h0);  // zero servers
      send_request(tbc_pkg::FN_PLAIN_B, 1023, 32'hFFFF_FFFF, 16'hFFFF, 17'h1FFFF);
      send_request(tbc_pkg::FN_PLAIN_B, 1, 32'h0000_0001, 16'h0, 17'h0);
      send_request(tbc_pkg::FN_EXT_B, 8, 32'h0004_0000, 16'h0, 17'h0);
      send_request(tbc_pkg::FN_EXT_B, 8, 32'h0004_0000, 16'hFFFF, 17'h0);  // full retry
      send_request(tbc_pkg::FN_EXT_B, 0, 32'h0002_0000, 16'h8000, 17'h0);
      send_request(tbc_pkg::FN_EXT_B, 5, 32'h0, 16'h8000, 17'h0);
      send_request(tbc_pkg::FN_EXT_B, 1023, 32'h0200_0000, 16'h4000, 17'h0);
      send_request(tbc_pkg::FN_ERLANG_C, 10, 32'h0005_0000, 16'h0, 17'h0);
      send_request(tbc_pkg::FN_ERLANG_C, 0, 32'h0005_0000, 16'h0, 17'h0);  // no servers
      send_request(tbc_pkg::FN_ERLANG_C, 5, 32'h000A_0000, 16'h0, 17'h0);  // overloaded
      send_request(tbc_pkg::FN_ERLANG_C, 5, 32'h0005_0000, 16'h0, 17'h0);  // traffic is n
      send_request(tbc_pkg::FN_ERLANG_C, 3, 32'h0, 16'h0, 17'h0);
      send_request(tbc_pkg::FN_TRUNKS, 0, 32'h0005_0000, 16'h0, 17'd655);
      send_request(tbc_pkg::FN_TRUNKS, 7, 32'h0005_0000, 16'h0, 17'h10000); // target one
      send_request(tbc_pkg::FN_TRUNKS, 0, 32'hFFFF_FFFF, 16'h0, 17'h0);    // search fails
      send_request(tbc_pkg::FN_TRUNKS, 0, 32'h0, 16'h0, 17'h0);

      // random phases: no idling, idle sender, stalling receiver, both rarely
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct   = (phase == 1) ? 75 : (phase == 3) ? 7 : 0;
         drain_stall_pct = (phase == 2) ? 75 : (phase == 3) ? 7 : 0;
         for (int i = 0; i < 25; i++) begin
            send_random_request();
         end
      end

      wait (requests_sent == words_checked && pending == 0);
      repeat (100) @(posedge clock);
      $display("summary: %0d requests over four idling phases, %0d responses checked",
               requests_sent, words_checked);
      $display("summary: response side held off for %0d cycles", hold_off_cycles);
      if (failures == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Give up well beyond the slowest correct run.
   initial begin
      #(100_000_000);
      $display("tb: failure");
      $finish;
   end

endmodule

// ----- sim.f -----
sv/tbc_pkg.sv
sv/tbc_div.sv
sv/teletraffic_blocking_calc.sv
dv/tbc_checker.sv
dv/testbench.sv
